// File: rtl/pid_position_delta_controller_top_defines.svh
// Assertion macros for the controller top level
`ifndef PID_POSITION_DELTA_CONTROLLER_TOP_DEFINES_SVH
`define PID_POSITION_DELTA_CONTROLLER_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define PIDPD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check an implication within the same clock edge
`define PIDPD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication at the next clock edge
`define PIDPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pidpd_pkg.sv
package pidpd_pkg;

    localparam int DEFAULT_SAMPLE_WIDTH = 16;
    localparam int DEFAULT_FRAC_BITS    = 8;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 15;
    localparam int GATE_W      = 16;
    localparam int DRIVE_W     = 16;

    localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST   = 15'h7FFF;
    localparam logic [LIMIT_W-1:0] INTEGRAL_CLAMP_RST = 15'h7FFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LOOP_MODE       = 4'd0,
        REG_OUTPUT_LIMIT    = 4'd1,
        REG_INTEGRAL_CLAMP  = 4'd2,
        REG_GAIN_PROP       = 4'd3,
        REG_GAIN_INTEG      = 4'd4,
        REG_GAIN_DERIV      = 4'd5,
        REG_ERROR_GATE      = 4'd6,
        REG_DEAD_ZONE       = 4'd7
    } reg_index_t;

    typedef enum logic {
        MODE_POSITION = 1'b0,
        MODE_DELTA    = 1'b1
    } loop_mode_t;

    typedef enum logic {
        CMD_RUN   = 1'b0,
        CMD_CLEAR = 1'b1
    } command_t;

    typedef struct packed {
        loop_mode_t                 loop_mode;
        logic [LIMIT_W-1:0]         output_limit;
        logic [LIMIT_W-1:0]         integral_clamp;
        logic signed [GAIN_W-1:0]   gain_prop;
        logic signed [GAIN_W-1:0]   gain_integ;
        logic signed [GAIN_W-1:0]   gain_deriv;
        logic [GATE_W-1:0]          error_gate;
        logic [LIMIT_W-1:0]         dead_zone;
    } cfg_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0]  drive;
        logic                       gated;
        logic                       in_deadband;
    } result_t;

endpackage

// File: rtl/pid_position_delta_controller_top.sv
// PID controller with positional and incremental forms. Each input transaction
// yields exactly one result transaction. A transaction is held in an input
// register, the error, the three gain products, the integral and output clamps
// and the deadband are formed combinationally from it and the stored history,
// and the result lands in an output register when that register is empty or
// its result is taken: m_valid rises at the edge that moves the transaction
// across, and a new transaction is taken every cycle while m_ready is high.
// The cycle is set by the three signed gain multipliers followed by the
// integral clamp, the output sum and the output clamp. Configuration writes
// take effect at the next clock edge and must only be made while no
// transaction is in flight.
`include "pid_position_delta_controller_top_defines.svh"

module pid_position_delta_controller_top #(
    parameter int SAMPLE_WIDTH = pidpd_pkg::DEFAULT_SAMPLE_WIDTH,
    parameter int FRAC_BITS    = pidpd_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [pidpd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [pidpd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_command,
    input  logic signed [SAMPLE_WIDTH-1:0]          s_measured,
    input  logic signed [SAMPLE_WIDTH-1:0]          s_target,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [pidpd_pkg::DRIVE_W-1:0]    m_drive,
    output logic                                    m_gated,
    output logic                                    m_in_deadband
);

    pidpd_pkg::cfg_t                cfg;
    pidpd_pkg::result_t             step_result;
    pidpd_pkg::result_t             out_result_reg;

    logic                           in_valid_reg;
    pidpd_pkg::command_t            in_command_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_measured_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_target_reg;
    logic                           out_valid_reg;
    logic                           advance;

    pidpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_command_reg  <= pidpd_pkg::command_t'(s_command);
            in_measured_reg <= s_measured;
            in_target_reg   <= s_target;
        end
    end

    pidpd_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .step_en  (advance),
        .command  (in_command_reg),
        .measured (in_measured_reg),
        .target   (in_target_reg),
        .result   (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_drive       = out_result_reg.drive;
    assign m_gated       = out_result_reg.gated;
    assign m_in_deadband = out_result_reg.in_deadband;

    `PIDPD_ASSERT_ALWAYS(a_flags_exclusive, !(m_valid && m_gated && m_in_deadband), "gate and deadband flags both set")
    `PIDPD_ASSERT_IMPL(a_flag_zero_drive, m_valid && (m_gated || m_in_deadband), m_drive == '0, "flagged result with nonzero drive")
    `PIDPD_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg, "advanced transaction lost")

endmodule

// File: rtl/pidpd_cfg.sv
module pidpd_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [pidpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pidpd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output pidpd_pkg::cfg_t                     cfg
);

    pidpd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.loop_mode       <= pidpd_pkg::MODE_POSITION;
            cfg_reg.output_limit    <= pidpd_pkg::OUTPUT_LIMIT_RST;
            cfg_reg.integral_clamp  <= pidpd_pkg::INTEGRAL_CLAMP_RST;
            cfg_reg.gain_prop       <= '0;
            cfg_reg.gain_integ      <= '0;
            cfg_reg.gain_deriv      <= '0;
            cfg_reg.error_gate      <= '0;
            cfg_reg.dead_zone       <= '0;
        end else if (cfg_wr_en) begin
            case (pidpd_pkg::reg_index_t'(cfg_index))
                pidpd_pkg::REG_LOOP_MODE: begin
                    cfg_reg.loop_mode <= pidpd_pkg::loop_mode_t'(cfg_wdata[0]);
                end
                pidpd_pkg::REG_OUTPUT_LIMIT: begin
                    cfg_reg.output_limit <= cfg_wdata[pidpd_pkg::LIMIT_W-1:0];
                end
                pidpd_pkg::REG_INTEGRAL_CLAMP: begin
                    cfg_reg.integral_clamp <= cfg_wdata[pidpd_pkg::LIMIT_W-1:0];
                end
                pidpd_pkg::REG_GAIN_PROP: begin
                    cfg_reg.gain_prop <= $signed(cfg_wdata[pidpd_pkg::GAIN_W-1:0]);
                end
                pidpd_pkg::REG_GAIN_INTEG: begin
                    cfg_reg.gain_integ <= $signed(cfg_wdata[pidpd_pkg::GAIN_W-1:0]);
                end
                pidpd_pkg::REG_GAIN_DERIV: begin
                    cfg_reg.gain_deriv <= $signed(cfg_wdata[pidpd_pkg::GAIN_W-1:0]);
                end
                pidpd_pkg::REG_ERROR_GATE: begin
                    cfg_reg.error_gate <= cfg_wdata[pidpd_pkg::GATE_W-1:0];
                end
                pidpd_pkg::REG_DEAD_ZONE: begin
                    cfg_reg.dead_zone <= cfg_wdata[pidpd_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/pidpd_core.sv
module pidpd_core #(
    parameter int SAMPLE_WIDTH = pidpd_pkg::DEFAULT_SAMPLE_WIDTH,
    parameter int FRAC_BITS    = pidpd_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  pidpd_pkg::cfg_t                 cfg,
    input  logic                            step_en,
    input  pidpd_pkg::command_t             command,
    input  logic signed [SAMPLE_WIDTH-1:0]  measured,
    input  logic signed [SAMPLE_WIDTH-1:0]  target,
    output pidpd_pkg::result_t              result
);

    localparam int ERR_W  = SAMPLE_WIDTH + 1;
    localparam int DIF_W  = SAMPLE_WIDTH + 3;
    localparam int PROD_W = DIF_W + pidpd_pkg::GAIN_W;
    localparam int ACC_W  = pidpd_pkg::LIMIT_W + FRAC_BITS + 1;
    localparam int SUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 2;
    localparam int CMP_W  = (ERR_W > pidpd_pkg::GATE_W) ? ERR_W : pidpd_pkg::GATE_W;

    logic signed [ERR_W-1:0]    err_prev_reg;
    logic signed [ERR_W-1:0]    err_prev2_reg;
    logic signed [ACC_W-1:0]    integ_acc_reg;
    logic signed [ACC_W-1:0]    out_acc_reg;

    logic signed [ERR_W-1:0]    err;
    logic [ERR_W-1:0]           err_mag;
    logic                       gate_hit;
    logic                       delta_mode;

    logic signed [DIF_W-1:0]    err_d;
    logic signed [DIF_W-1:0]    prev_d;
    logic signed [DIF_W-1:0]    prev2_d;
    logic signed [DIF_W-1:0]    diff1;
    logic signed [DIF_W-1:0]    diff2;
    logic signed [DIF_W-1:0]    op_a;
    logic signed [DIF_W-1:0]    op_c;

    logic signed [PROD_W-1:0]   prod_a;
    logic signed [PROD_W-1:0]   prod_b;
    logic signed [PROD_W-1:0]   prod_c;

    logic signed [SUM_W-1:0]    ilim;
    logic signed [SUM_W-1:0]    olim;
    logic signed [SUM_W-1:0]    integ_sum;
    logic signed [SUM_W-1:0]    integ_clamped;
    logic signed [SUM_W-1:0]    out_base;
    logic signed [SUM_W-1:0]    out_sum;
    logic signed [SUM_W-1:0]    out_clamped;

    logic signed [ACC_W-1:0]    integ_next;
    logic signed [ACC_W-1:0]    out_next;
    logic [ACC_W-1:0]           out_mag;
    logic [ACC_W-1:0]           db_lim;
    logic                       db_hit;
    logic signed [ACC_W-1:0]    bias;
    logic signed [ACC_W-1:0]    rounded;

    assign delta_mode = (cfg.loop_mode == pidpd_pkg::MODE_DELTA);

    assign err      = ERR_W'(target) - ERR_W'(measured);
    assign err_mag  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    assign gate_hit = (cfg.error_gate != '0) &&
                      (CMP_W'(err_mag) > CMP_W'(cfg.error_gate));

    assign err_d   = DIF_W'(err);
    assign prev_d  = DIF_W'(err_prev_reg);
    assign prev2_d = DIF_W'(err_prev2_reg);
    assign diff1   = err_d - prev_d;
    assign diff2   = err_d - (prev_d <<< 1) + prev2_d;
    assign op_a    = delta_mode ? diff1 : err_d;
    assign op_c    = delta_mode ? diff2 : diff1;

    assign prod_a = $signed(cfg.gain_prop) * op_a;
    assign prod_b = $signed(cfg.gain_integ) * err_d;
    assign prod_c = $signed(cfg.gain_deriv) * op_c;

    assign ilim = $signed(SUM_W'(cfg.integral_clamp) << FRAC_BITS);
    assign olim = $signed(SUM_W'(cfg.output_limit) << FRAC_BITS);

    assign integ_sum = SUM_W'(integ_acc_reg) + SUM_W'(prod_b);

    always_comb begin
        if (integ_sum > ilim) begin
            integ_clamped = ilim;
        end else if (integ_sum < -ilim) begin
            integ_clamped = -ilim;
        end else begin
            integ_clamped = integ_sum;
        end
    end

    assign integ_next = ACC_W'(integ_clamped);
    assign out_base   = delta_mode ? (SUM_W'(out_acc_reg) + SUM_W'(prod_b)) : integ_clamped;
    assign out_sum    = SUM_W'(prod_a) + SUM_W'(prod_c) + out_base;

    always_comb begin
        if (out_sum > olim) begin
            out_clamped = olim;
        end else if (out_sum < -olim) begin
            out_clamped = -olim;
        end else begin
            out_clamped = out_sum;
        end
    end

    assign out_next = ACC_W'(out_clamped);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_prev_reg  <= '0;
            err_prev2_reg <= '0;
            integ_acc_reg <= '0;
            out_acc_reg   <= '0;
        end else if (step_en) begin
            if (command == pidpd_pkg::CMD_CLEAR) begin
                err_prev_reg  <= '0;
                err_prev2_reg <= '0;
                integ_acc_reg <= '0;
                out_acc_reg   <= '0;
            end else if (!gate_hit) begin
                err_prev2_reg <= err_prev_reg;
                err_prev_reg  <= err;
                if (!delta_mode) begin
                    integ_acc_reg <= integ_next;
                end
                out_acc_reg <= out_next;
            end
        end
    end

    assign out_mag = out_next[ACC_W-1] ? ACC_W'(-out_next) : ACC_W'(out_next);
    assign db_lim  = ACC_W'(cfg.dead_zone) << FRAC_BITS;
    assign db_hit  = (cfg.dead_zone != '0) && (out_mag < db_lim);
    assign bias    = out_next[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : '0;
    assign rounded = out_next + bias;

    always_comb begin
        result = '0;
        if (command == pidpd_pkg::CMD_CLEAR) begin
            result = '0;
        end else if (gate_hit) begin
            result.gated = 1'b1;
        end else if (db_hit) begin
            result.in_deadband = 1'b1;
        end else begin
            result.drive = rounded[ACC_W-1:FRAC_BITS];
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import pidpd_pkg::*;

    localparam int SAMPLE_W    = DEFAULT_SAMPLE_WIDTH;
    localparam int FRAC        = DEFAULT_FRAC_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1550;

    typedef struct packed {
        command_t                    command;
        logic signed [SAMPLE_W-1:0]  measured;
        logic signed [SAMPLE_W-1:0]  target;
    } sample_t;

    logic                          aclk;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_wdata = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_command = 1'b0;
    logic signed [SAMPLE_W-1:0]    s_measured = '0;
    logic signed [SAMPLE_W-1:0]    s_target = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [DRIVE_W-1:0]     m_drive;
    logic                          m_gated;
    logic                          m_in_deadband;

    // controller copy: registers and history
    cfg_t                          ctrl_cfg;
    logic signed [16:0]            err_last = '0;
    logic signed [16:0]            err_before = '0;
    logic signed [23:0]            integ_sum = '0;
    logic signed [23:0]            out_sum = '0;

    sample_t                       pending_samples[$];
    result_t                       expected_results[$];

    bit                            no_idle = 1'b0;
    int                            mismatches = 0;
    int                            cycle_count = 0;
    int                            accepted_count = 0;
    int                            clear_count = 0;
    int                            gated_seen = 0;
    int                            deadband_seen = 0;
    int                            nonzero_seen = 0;
    int                            settings_count = 0;

    pid_position_delta_controller_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_measured    (s_measured),
        .s_target      (s_target),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive       (m_drive),
        .m_gated       (m_gated),
        .m_in_deadband (m_in_deadband)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic longint clamp_sym(longint x, longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    function automatic longint magnitude(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic result_t control_step(command_t cmd, logic signed [SAMPLE_W-1:0] meas,
                                             logic signed [SAMPLE_W-1:0] tgt);
        result_t r;
        longint  one;
        longint  err;
        longint  olim;
        longint  acc;
        longint  q;
        r = '0;
        one = longint'(1) <<< FRAC;
        if (cmd == CMD_CLEAR) begin
            err_last = '0;
            err_before = '0;
            integ_sum = '0;
            out_sum = '0;
            return r;
        end
        err = longint'(tgt) - longint'(meas);
        if (ctrl_cfg.error_gate != 0 && magnitude(err) > longint'(ctrl_cfg.error_gate)) begin
            r.gated = 1'b1;
            return r;
        end
        olim = longint'(ctrl_cfg.output_limit) * one;
        if (ctrl_cfg.loop_mode == MODE_POSITION) begin
            acc = clamp_sym(longint'(integ_sum) + longint'(ctrl_cfg.gain_integ) * err,
                            longint'(ctrl_cfg.integral_clamp) * one);
            integ_sum = acc;
            acc = longint'(ctrl_cfg.gain_prop) * err + longint'(integ_sum)
                + longint'(ctrl_cfg.gain_deriv) * (err - longint'(err_last));
        end else begin
            acc = longint'(out_sum)
                + longint'(ctrl_cfg.gain_prop) * (err - longint'(err_last))
                + longint'(ctrl_cfg.gain_integ) * err
                + longint'(ctrl_cfg.gain_deriv)
                  * (err - 2 * longint'(err_last) + longint'(err_before));
        end
        out_sum = clamp_sym(acc, olim);
        err_before = err_last;
        err_last = err;
        if (ctrl_cfg.dead_zone != 0
            && magnitude(longint'(out_sum)) < longint'(ctrl_cfg.dead_zone) * one) begin
            r.in_deadband = 1'b1;
            return r;
        end
        q = longint'(out_sum) / one;
        r.drive = q[DRIVE_W-1:0];
        return r;
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_LOOP_MODE:       ctrl_cfg.loop_mode = loop_mode_t'(val[0]);
            REG_OUTPUT_LIMIT:    ctrl_cfg.output_limit = val[LIMIT_W-1:0];
            REG_INTEGRAL_CLAMP:  ctrl_cfg.integral_clamp = val[LIMIT_W-1:0];
            REG_GAIN_PROP:       ctrl_cfg.gain_prop = val;
            REG_GAIN_INTEG:      ctrl_cfg.gain_integ = val;
            REG_GAIN_DERIV:      ctrl_cfg.gain_deriv = val;
            REG_ERROR_GATE:      ctrl_cfg.error_gate = val;
            REG_DEAD_ZONE:       ctrl_cfg.dead_zone = val[LIMIT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_limit();
        case ($urandom_range(9))
            0:       return '0;
            1, 2:    return '1;
            3, 4:    return CFG_DATA_W'($urandom_range(300));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_gain();
        case ($urandom_range(9))
            0:             return 16'h8000;
            1:             return 16'h7FFF;
            2, 3, 4, 5:    return CFG_DATA_W'(int'($urandom_range(1024)) - 512);
            default:       return CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic randomise_config();
        logic [CFG_DATA_W-1:0] gate_val;
        logic [CFG_DATA_W-1:0] band_val;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: gate_val = '0;
            5:             gate_val = '1;
            6, 7:          gate_val = CFG_DATA_W'($urandom_range(400));
            default:       gate_val = CFG_DATA_W'($urandom);
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4: band_val = '0;
            5, 6:          band_val = CFG_DATA_W'($urandom_range(60));
            7:             band_val = '1;
            default:       band_val = CFG_DATA_W'($urandom);
        endcase
        write_reg(REG_LOOP_MODE, CFG_DATA_W'($urandom));
        write_reg(REG_OUTPUT_LIMIT, random_limit());
        write_reg(REG_INTEGRAL_CLAMP, random_limit());
        write_reg(REG_GAIN_PROP, random_gain());
        write_reg(REG_GAIN_INTEG, random_gain());
        write_reg(REG_GAIN_DERIV, random_gain());
        write_reg(REG_ERROR_GATE, gate_val);
        write_reg(REG_DEAD_ZONE, band_val);
        if ($urandom_range(3) == 0)
            write_reg(CFG_INDEX_W'(REG_DEAD_ZONE + 1 + $urandom_range(7)),
                      CFG_DATA_W'($urandom));
        settings_count++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] extreme_sample();
        case ($urandom_range(2))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return '0;
        endcase
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        int      tgt;
        s.command = ($urandom_range(99) < 4) ? CMD_CLEAR : CMD_RUN;
        s.measured = SAMPLE_W'($urandom);
        s.target = SAMPLE_W'($urandom);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                tgt = int'(s.measured) + int'($urandom_range(600)) - 300;
                if (tgt > 32767) tgt = 32767;
                if (tgt < -32768) tgt = -32768;
                s.target = tgt[SAMPLE_W-1:0];
            end
            5: begin
                s.measured = extreme_sample();
                s.target = extreme_sample();
            end
            6: begin
                s.measured = SAMPLE_W'(int'($urandom_range(64)) - 32);
                s.target = SAMPLE_W'(int'($urandom_range(64)) - 32);
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic queue_run(int meas, int tgt);
        sample_t s;
        s.command = CMD_RUN;
        s.measured = meas[SAMPLE_W-1:0];
        s.target = tgt[SAMPLE_W-1:0];
        pending_samples.push_back(s);
    endtask

    task automatic queue_clear();
        sample_t s;
        s = random_sample();
        s.command = CMD_CLEAR;
        pending_samples.push_back(s);
    endtask

    // hold the sender until every expected result is back
    task automatic settle();
        do @(negedge aclk);
        while (pending_samples.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        sample_t item_now;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(control_step(command_t'(s_command), s_measured,
                                                        s_target));
                accepted_count++;
                if (command_t'(s_command) == CMD_CLEAR) clear_count++;
            end
            if (!s_valid || s_ready) begin
                if (pending_samples.size() != 0 && (no_idle || $urandom_range(99) >= 8)) begin
                    item_now = pending_samples.pop_front();
                    s_valid <= 1'b1;
                    s_command <= item_now.command;
                    s_measured <= item_now.measured;
                    s_target <= item_now.target;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 8);
        end
    end

    // monitor
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction: drive %0d gated %0b in_deadband %0b",
                       m_drive, m_gated, m_in_deadband);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_drive !== want.drive) begin
                    $error("drive: expected %0d, got %0d", want.drive, m_drive);
                    mismatches++;
                end
                if (m_gated !== want.gated) begin
                    $error("gated: expected %0b, got %0b", want.gated, m_gated);
                    mismatches++;
                end
                if (m_in_deadband !== want.in_deadband) begin
                    $error("in_deadband: expected %0b, got %0b", want.in_deadband,
                           m_in_deadband);
                    mismatches++;
                end
                if (want.gated) gated_seen++;
                if (want.in_deadband) deadband_seen++;
                if (want.drive != 0) nonzero_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        int phase;
        int count;
        int random_items;
        ctrl_cfg.loop_mode = MODE_POSITION;
        ctrl_cfg.output_limit = OUTPUT_LIMIT_RST;
        ctrl_cfg.integral_clamp = INTEGRAL_CLAMP_RST;
        ctrl_cfg.gain_prop = '0;
        ctrl_cfg.gain_integ = '0;
        ctrl_cfg.gain_deriv = '0;
        ctrl_cfg.error_gate = '0;
        ctrl_cfg.dead_zone = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings
        queue_run(0, 100);
        queue_run(32767, -32768);
        queue_clear();
        settle();

        // position form, full-scale errors, fractional integral gain
        write_reg(REG_LOOP_MODE, MODE_POSITION);
        write_reg(REG_OUTPUT_LIMIT, 16'h7FFF);
        write_reg(REG_INTEGRAL_CLAMP, 16'd1000);
        write_reg(REG_GAIN_PROP, 16'h0100);
        write_reg(REG_GAIN_INTEG, 16'h0040);
        write_reg(REG_GAIN_DERIV, 16'hFF00);
        write_reg(REG_ERROR_GATE, 16'd0);
        write_reg(REG_DEAD_ZONE, 16'd0);
        queue_run(-32768, 32767);
        queue_run(32767, -32768);
        queue_run(0, 0);
        queue_run(10, 13);
        queue_run(13, 10);
        queue_clear();
        queue_run(0, -7);
        settle();

        // delta form, extreme gains, error gate at its boundary
        write_reg(REG_LOOP_MODE, MODE_DELTA);
        write_reg(REG_OUTPUT_LIMIT, 16'd1000);
        write_reg(REG_GAIN_PROP, 16'h7FFF);
        write_reg(REG_GAIN_INTEG, 16'h8000);
        write_reg(REG_GAIN_DERIV, 16'h0001);
        write_reg(REG_ERROR_GATE, 16'd500);
        queue_run(0, 500);
        queue_run(0, 501);
        queue_run(0, -501);
        queue_run(0, -500);
        queue_run(-200, -100);
        queue_run(5, 5);
        settle();

        // deadband edges, widest gate, zero integral clamp
        write_reg(REG_LOOP_MODE, MODE_POSITION);
        write_reg(REG_OUTPUT_LIMIT, 16'h7FFF);
        write_reg(REG_INTEGRAL_CLAMP, 16'd0);
        write_reg(REG_GAIN_PROP, 16'h0100);
        write_reg(REG_GAIN_INTEG, 16'h0000);
        write_reg(REG_GAIN_DERIV, 16'h0000);
        write_reg(REG_ERROR_GATE, 16'hFFFF);
        write_reg(REG_DEAD_ZONE, 16'd50);
        queue_run(0, 49);
        queue_run(0, 50);
        queue_run(0, -49);
        queue_run(0, -50);
        queue_run(1, 0);
        queue_run(-32768, 32767);
        settle();

        // switch to delta form and carry on from the last output
        write_reg(REG_LOOP_MODE, MODE_DELTA);
        write_reg(REG_GAIN_INTEG, 16'h0100);
        queue_run(0, 3);
        queue_run(0, 3);
        queue_clear();
        settle();
        settings_count = 5;

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            randomise_config();
            no_idle = (phase == 6);
            count = no_idle ? 200 : $urandom_range(30, 90);
            repeat (count) pending_samples.push_back(random_sample());
            random_items += count;
            settle();
            phase++;
        end
        no_idle = 1'b0;

        repeat (10) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatches++;
        end
        $display("Ran %0d transactions (%0d clears) across %0d register settings",
                 accepted_count, clear_count, settings_count);
        $display("Results: %0d gated, %0d in deadband, %0d with non-zero drive, %0d mismatches",
                 gated_seen, deadband_seen, nonzero_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
